@@ hw/rtl/rri_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rri_pkg
// Shared types, register codes and helpers of the ray rectangle intersection.
// ----------------------------------------------------------------------------
package rri_pkg;

   localparam int unsigned DivBits = 32;
   localparam int unsigned RemBits = 66;

   typedef enum logic [2:0] {
      REG_CENTER      = 3'd0,
      REG_NORMAL      = 3'd1,
      REG_RIGHT_AXIS  = 3'd2,
      REG_UP_AXIS     = 3'd3,
      REG_HALF_WIDTH  = 3'd4,
      REG_HALF_HEIGHT = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic signed [15:0] origin_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } ray_type;

   typedef struct packed {
      logic [47:0] center;
      logic [47:0] normal;
      logic [47:0] right_axis;
      logic [47:0] up_axis;
      logic [14:0] half_width;
      logic [14:0] half_height;
   } cfg_type;

   typedef struct packed {
      ray_type ray;
      logic    neg;
      logic    ovf;
      logic    zero;
   } side_type;

   function automatic logic signed [15:0] vec_comp(input logic [47:0] v,
                                                   input logic [1:0] k);
      logic signed [15:0] r;
      case (k)
         2'd0:    r = v[15:0];
         2'd1:    r = v[31:16];
         default: r = v[47:32];
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
      logic signed [15:0] r;
      if (v > 33'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -33'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rri_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rri_front
// Forms the plane dot products and prepares the magnitudes for the divider.
// ----------------------------------------------------------------------------
module rri_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire rri_pkg::ray_type  in_ray,
   input  wire rri_pkg::cfg_type  cfg,
   output logic                   out_valid,
   output logic [50:0]            out_num,
   output logic [33:0]            out_den,
   output rri_pkg::side_type      out_side
);
   import rri_pkg::*;

   logic signed [15:0] o_v [3];
   logic signed [15:0] d_v [3];
   logic signed [15:0] c_v [3];
   logic signed [15:0] n_v [3];
   logic signed [16:0] co_v [3];

   logic               s1_valid_ff;
   ray_type            s1_ray_ff;
   logic signed [31:0] s1_dn_ff [3];
   logic signed [32:0] s1_nco_ff [3];

   logic               s2_valid_ff;
   ray_type            s2_ray_ff;
   logic signed [33:0] s2_denom_ff;
   logic signed [34:0] s2_numer_ff;

   logic               s3_valid_ff;
   logic [50:0]        s3_num_ff;
   logic [33:0]        s3_den_ff;
   side_type           s3_side_ff;

   logic [34:0]        num_abs_in;
   logic [33:0]        den_abs_in;
   logic [50:0]        num_sh_in;
   side_type           side_in;

   assign o_v[0] = in_ray.origin_x;
   assign o_v[1] = in_ray.origin_y;
   assign o_v[2] = in_ray.origin_z;
   assign d_v[0] = in_ray.dir_x;
   assign d_v[1] = in_ray.dir_y;
   assign d_v[2] = in_ray.dir_z;

   for (genvar k = 0; k < 3; k++) begin : g_vec
      assign c_v[k]  = vec_comp(cfg.center, 2'(k));
      assign n_v[k]  = vec_comp(cfg.normal, 2'(k));
      assign co_v[k] = 17'(c_v[k]) - 17'(o_v[k]);
      always_ff @(posedge clock) begin
         if (en) begin
            s1_dn_ff[k]  <= d_v[k] * n_v[k];
            s1_nco_ff[k] <= 33'(n_v[k]) * 33'(co_v[k]);
         end
      end
   end

   always_comb begin
      num_abs_in = s2_numer_ff[34] ? 35'(-s2_numer_ff) : 35'(s2_numer_ff);
      den_abs_in = s2_denom_ff[33] ? 34'(-s2_denom_ff) : 34'(s2_denom_ff);
      num_sh_in  = {num_abs_in, 16'd0};
      side_in.ray  = s2_ray_ff;
      side_in.neg  = s2_numer_ff[34] ^ s2_denom_ff[33];
      side_in.zero = (s2_denom_ff == 34'sd0);
      side_in.ovf  = ({15'd0, num_sh_in} >= {den_abs_in, 32'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ray_ff   <= in_ray;
         s2_ray_ff   <= s1_ray_ff;
         s2_denom_ff <= 34'(s1_dn_ff[0]) + 34'(s1_dn_ff[1]) + 34'(s1_dn_ff[2]);
         s2_numer_ff <= 35'(s1_nco_ff[0]) + 35'(s1_nco_ff[1]) + 35'(s1_nco_ff[2]);
         s3_num_ff   <= num_sh_in;
         s3_den_ff   <= den_abs_in;
         s3_side_ff  <= side_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_num   = s3_num_ff;
   assign out_den   = s3_den_ff;
   assign out_side  = s3_side_ff;

endmodule
`default_nettype wire

@@ hw/rtl/rri_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rri_divider
// Restoring divider with one quotient bit resolved per pipeline stage.
// ----------------------------------------------------------------------------
module rri_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire logic [50:0]                in_num,
   input  wire logic [33:0]                in_den,
   input  wire rri_pkg::side_type          in_side,
   output logic                            out_valid,
   output logic [rri_pkg::DivBits-1:0]     out_quo,
   output rri_pkg::side_type               out_side
);
   import rri_pkg::*;

   logic                 valid_ff [DivBits];
   logic [RemBits-1:0]   rem_ff   [DivBits];
   logic [DivBits-1:0]   quo_ff   [DivBits];
   logic [33:0]          den_ff   [DivBits];
   side_type             side_ff  [DivBits];

   for (genvar s = 0; s < DivBits; s++) begin : g_stage
      localparam int unsigned Bit = DivBits - 1 - s;
      logic                 pv;
      logic [RemBits-1:0]   prem;
      logic [DivBits-1:0]   pquo;
      logic [33:0]          pden;
      side_type             pside;
      logic [RemBits-1:0]   den_sh;
      logic                 take;
      logic [DivBits-1:0]   qnext;

      if (s == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = {15'd0, in_num};
         assign pquo  = '0;
         assign pden  = in_den;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = valid_ff[s-1];
         assign prem  = rem_ff[s-1];
         assign pquo  = quo_ff[s-1];
         assign pden  = den_ff[s-1];
         assign pside = side_ff[s-1];
      end

      assign den_sh = {32'd0, pden} << Bit;
      assign take   = (prem >= den_sh);
      assign qnext  = pquo | (DivBits'(take) << Bit);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= take ? prem - den_sh : prem;
            quo_ff[s]  <= qnext;
            den_ff[s]  <= pden;
            side_ff[s] <= pside;
         end
      end
   end

   assign out_valid = valid_ff[DivBits-1];
   assign out_quo   = quo_ff[DivBits-1];
   assign out_side  = side_ff[DivBits-1];

endmodule
`default_nettype wire

@@ hw/rtl/rri_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rri_back
// Saturates t, forms the plane point and runs the ahead and inside tests.
// ----------------------------------------------------------------------------
module rri_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [rri_pkg::DivBits-1:0] in_quo,
   input  wire rri_pkg::side_type       in_side,
   input  wire rri_pkg::cfg_type        cfg,
   output logic                         out_valid,
   output logic                         out_hit,
   output logic                         out_point_valid,
   output logic signed [15:0]           out_x,
   output logic signed [15:0]           out_y,
   output logic signed [15:0]           out_z
);
   import rri_pkg::*;

   logic signed [31:0] t_in;

   logic               b1_valid_ff;
   logic signed [31:0] b1_t_ff;
   side_type           b1_side_ff;

   logic               b2_valid_ff;
   logic signed [47:0] b2_prod_ff [3];
   side_type           b2_side_ff;

   logic               b3_valid_ff;
   logic signed [15:0] b3_p_ff [3];
   side_type           b3_side_ff;

   logic               b4_valid_ff;
   logic signed [32:0] b4_dpo_ff [3];
   logic signed [32:0] b4_rpc_ff [3];
   logic signed [32:0] b4_upc_ff [3];
   logic signed [15:0] b4_p_ff [3];
   logic               b4_zero_ff;

   logic               out_valid_ff;
   logic               out_hit_ff;
   logic               out_pv_ff;
   logic signed [15:0] out_p_ff [3];

   logic signed [15:0] d1_v [3];
   logic signed [15:0] o2_v [3];
   logic signed [15:0] o3_v [3];
   logic signed [15:0] d3_v [3];
   logic signed [15:0] c_v  [3];
   logic signed [15:0] r_v  [3];
   logic signed [15:0] u_v  [3];

   logic signed [34:0] ahead_in;
   logic signed [34:0] xd_in;
   logic signed [34:0] yd_in;
   logic [34:0]        xa_in;
   logic [34:0]        ya_in;
   logic               hit_in;

   always_comb begin
      if (in_side.ovf) begin
         t_in = in_side.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (in_side.neg) begin
         t_in = in_quo[31] ? 32'sh8000_0000 : -$signed(in_quo);
      end else begin
         t_in = in_quo[31] ? 32'sh7fff_ffff : $signed(in_quo);
      end
   end

   assign d1_v[0] = b1_side_ff.ray.dir_x;
   assign d1_v[1] = b1_side_ff.ray.dir_y;
   assign d1_v[2] = b1_side_ff.ray.dir_z;
   assign o2_v[0] = b2_side_ff.ray.origin_x;
   assign o2_v[1] = b2_side_ff.ray.origin_y;
   assign o2_v[2] = b2_side_ff.ray.origin_z;
   assign o3_v[0] = b3_side_ff.ray.origin_x;
   assign o3_v[1] = b3_side_ff.ray.origin_y;
   assign o3_v[2] = b3_side_ff.ray.origin_z;
   assign d3_v[0] = b3_side_ff.ray.dir_x;
   assign d3_v[1] = b3_side_ff.ray.dir_y;
   assign d3_v[2] = b3_side_ff.ray.dir_z;

   for (genvar k = 0; k < 3; k++) begin : g_vec
      logic signed [16:0] po;
      logic signed [16:0] pc;
      logic signed [32:0] pt;
      assign c_v[k] = vec_comp(cfg.center, 2'(k));
      assign r_v[k] = vec_comp(cfg.right_axis, 2'(k));
      assign u_v[k] = vec_comp(cfg.up_axis, 2'(k));
      assign pt = 33'(o2_v[k]) + 33'($signed(b2_prod_ff[k][47:16]));
      assign po = 17'(b3_p_ff[k]) - 17'(o3_v[k]);
      assign pc = 17'(b3_p_ff[k]) - 17'(c_v[k]);
      always_ff @(posedge clock) begin
         if (en) begin
            b2_prod_ff[k] <= 48'(d1_v[k]) * 48'(b1_t_ff);
            b3_p_ff[k]    <= sat16(pt);
            b4_dpo_ff[k]  <= 33'(d3_v[k]) * 33'(po);
            b4_rpc_ff[k]  <= 33'(r_v[k]) * 33'(pc);
            b4_upc_ff[k]  <= 33'(u_v[k]) * 33'(pc);
            b4_p_ff[k]    <= b3_p_ff[k];
            out_p_ff[k]   <= b4_zero_ff ? 16'sd0 : b4_p_ff[k];
         end
      end
   end

   always_comb begin
      ahead_in = 35'(b4_dpo_ff[0]) + 35'(b4_dpo_ff[1]) + 35'(b4_dpo_ff[2]);
      xd_in    = 35'(b4_rpc_ff[0]) + 35'(b4_rpc_ff[1]) + 35'(b4_rpc_ff[2]);
      yd_in    = 35'(b4_upc_ff[0]) + 35'(b4_upc_ff[1]) + 35'(b4_upc_ff[2]);
      xa_in    = xd_in[34] ? 35'(-xd_in) : 35'(xd_in);
      ya_in    = yd_in[34] ? 35'(-yd_in) : 35'(yd_in);
      hit_in   = !b4_zero_ff && (ahead_in > 35'sd0) &&
                 (xa_in < {12'd0, cfg.half_width, 8'd0}) &&
                 (ya_in < {12'd0, cfg.half_height, 8'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff  <= in_valid;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         b4_valid_ff  <= b3_valid_ff;
         out_valid_ff <= b4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_t_ff    <= t_in;
         b1_side_ff <= in_side;
         b2_side_ff <= b1_side_ff;
         b3_side_ff <= b2_side_ff;
         b4_zero_ff <= b3_side_ff.zero;
         out_hit_ff <= hit_in;
         out_pv_ff  <= !b4_zero_ff;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_hit         = out_hit_ff;
   assign out_point_valid = out_pv_ff;
   assign out_x           = out_p_ff[0];
   assign out_y           = out_p_ff[1];
   assign out_z           = out_p_ff[2];

endmodule
`default_nettype wire

@@ hw/rtl/ray_rectangle_intersect.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_rectangle_intersect
// Tests one Q8.8 ray per cycle, when not stalled, against a rectangle held in registers.
// ----------------------------------------------------------------------------
// The block takes one ray every clock cycle while the output is not stalled
// and returns one result word per ray, in order: three stages form the dot
// products, 32 stages of the restoring divider each resolve one bit of t, and
// five stages form the point and run the hit tests. The whole pipeline holds
// while a finished word is stalled at the output.
module ray_rectangle_intersect (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_origin_x,
   input  wire logic signed [15:0] req_origin_y,
   input  wire logic signed [15:0] req_origin_z,
   input  wire logic signed [15:0] req_dir_x,
   input  wire logic signed [15:0] req_dir_y,
   input  wire logic signed [15:0] req_dir_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_hit,
   output logic                    rsp_point_valid,
   output logic signed [15:0]      rsp_hit_x,
   output logic signed [15:0]      rsp_hit_y,
   output logic signed [15:0]      rsp_hit_z,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [5:0]         csr_paddr,
   input  wire logic [63:0]        csr_pwdata,
   output logic [63:0]             csr_prdata,
   output logic                    csr_pready
);
   import rri_pkg::*;

   cfg_type             cfg_ff;
   ray_type             ray;
   logic                en;
   logic                csr_wr;
   reg_index_type       csr_idx;

   logic                f_valid;
   logic [50:0]         f_num;
   logic [33:0]         f_den;
   side_type            f_side;
   logic                q_valid;
   logic [DivBits-1:0]  q_quo;
   side_type            q_side;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   assign ray.origin_x = req_origin_x;
   assign ray.origin_y = req_origin_y;
   assign ray.origin_z = req_origin_z;
   assign ray.dir_x    = req_dir_x;
   assign ray.dir_y    = req_dir_y;
   assign ray.dir_z    = req_dir_z;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CENTER:      cfg_ff.center      <= csr_pwdata[47:0];
            REG_NORMAL:      cfg_ff.normal      <= csr_pwdata[47:0];
            REG_RIGHT_AXIS:  cfg_ff.right_axis  <= csr_pwdata[47:0];
            REG_UP_AXIS:     cfg_ff.up_axis     <= csr_pwdata[47:0];
            REG_HALF_WIDTH:  cfg_ff.half_width  <= csr_pwdata[14:0];
            REG_HALF_HEIGHT: cfg_ff.half_height <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CENTER:      csr_prdata = {16'd0, cfg_ff.center};
         REG_NORMAL:      csr_prdata = {16'd0, cfg_ff.normal};
         REG_RIGHT_AXIS:  csr_prdata = {16'd0, cfg_ff.right_axis};
         REG_UP_AXIS:     csr_prdata = {16'd0, cfg_ff.up_axis};
         REG_HALF_WIDTH:  csr_prdata = {49'd0, cfg_ff.half_width};
         REG_HALF_HEIGHT: csr_prdata = {49'd0, cfg_ff.half_height};
         default:         csr_prdata = '0;
      endcase
   end

   rri_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_ray    (ray),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_num   (f_num),
      .out_den   (f_den),
      .out_side  (f_side)
   );

   rri_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_side   (f_side),
      .out_valid (q_valid),
      .out_quo   (q_quo),
      .out_side  (q_side)
   );

   rri_back u_back (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (q_valid),
      .in_quo          (q_quo),
      .in_side         (q_side),
      .cfg             (cfg_ff),
      .out_valid       (rsp_valid),
      .out_hit         (rsp_hit),
      .out_point_valid (rsp_point_valid),
      .out_x           (rsp_hit_x),
      .out_y           (rsp_hit_y),
      .out_z           (rsp_hit_z)
   );

endmodule
`default_nettype wire
